// File: hw/rtl/utf16_to_utf8_transcoder_assert.svh
// Assertion macros for the UTF-16 to UTF-8 transcoder.
// Each macro expects clk_i and rst_ni in scope.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define U2U_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U2U_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define U2U_ASSERT_IMP(lbl, ante, cons, msg)
`define U2U_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/u2u_pkg.sv
package u2u_pkg;

  // Width of the running unit position; the reported position is its low 32 bits.
  localparam int unsigned PositionBits = 32;
  localparam int unsigned ErrPosBits   = 32;
  localparam int unsigned MaxBytes     = 4;
  localparam int unsigned CntBits      = 3;

  // Classification masks and surrogate bases
  localparam logic [15:0] AsciiMask   = 16'hFF80;
  localparam logic [15:0] TwoByteMask = 16'hF800;
  localparam logic [15:0] SurrHiBase  = 16'hD800;
  localparam logic [15:0] SurrLoBase  = 16'hDC00;
  localparam logic [15:0] SurrSpan    = 16'h03FF;
  localparam logic [20:0] SuppBase    = 21'h10000;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] Lead2 = 8'b1100_0000;
  localparam logic [7:0] Cont  = 8'b1000_0000;
  localparam logic [7:0] Lead3 = 8'b1110_0000;
  localparam logic [7:0] Lead4 = 8'b1111_0000;

  // Register index of the byte-swap control
  localparam logic RegSwapBytes = 1'b0;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } in_word_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  last_of_run;
    logic                  error;
    logic [ErrPosBits-1:0] error_position;
  } out_word_t;

  // Stream state carried between units
  typedef struct packed {
    logic [9:0]              pend_bits;
    logic                    pend_valid;
    logic                    halted;
    logic [PositionBits-1:0] count;
  } state_t;

  // Results of converting one unit
  typedef struct packed {
    logic [CntBits-1:0]            nres;
    logic [MaxBytes-1:0][7:0]      bytes;
    logic                          err;
    logic [ErrPosBits-1:0]         err_pos;
  } conv_t;

endpackage

// File: hw/rtl/u2u_conv.sv
// Converts one code unit against the current stream state.
module u2u_conv (
  input  u2u_pkg::in_word_t word_i,
  input  logic              swap_i,
  input  u2u_pkg::state_t   state_i,
  output u2u_pkg::state_t   state_o,
  output u2u_pkg::conv_t    conv_o
);
  import u2u_pkg::*;

  logic [15:0]                        w;
  logic [15:0]                        lo;
  logic [15:0]                        hi;
  logic [20:0]                        v;
  logic [PositionBits-1:0]            pos_prev;
  logic [PositionBits-1:0]            cnt_next;
  logic [PositionBits+ErrPosBits-1:0] pos_ext;
  logic [PositionBits+ErrPosBits-1:0] prev_ext;

  always_comb begin
    w        = swap_i ? {word_i.code_unit[7:0], word_i.code_unit[15:8]} : word_i.code_unit;
    lo       = w - SurrLoBase;
    hi       = w - SurrHiBase;
    v        = {1'b0, state_i.pend_bits, 10'b0} + {11'b0, lo[9:0]} + SuppBase;
    pos_prev = state_i.count - PositionBits'(1);
    cnt_next = word_i.final_unit ? '0 : state_i.count + PositionBits'(1);
    pos_ext  = {{ErrPosBits{1'b0}}, state_i.count};
    prev_ext = {{ErrPosBits{1'b0}}, pos_prev};

    state_o = state_i;
    conv_o  = '0;

    if (!state_i.halted) begin
      if (state_i.pend_valid) begin
        if (lo > SurrSpan) begin
          // held high surrogate not followed by a low one
          conv_o.nres       = CntBits'(1);
          conv_o.err        = 1'b1;
          conv_o.err_pos    = prev_ext[ErrPosBits-1:0];
          state_o.halted    = 1'b1;
          state_o.pend_valid = 1'b0;
          state_o.pend_bits = '0;
        end else begin
          conv_o.nres     = CntBits'(4);
          conv_o.bytes[0] = Lead4 | {5'b0, v[20:18]};
          conv_o.bytes[1] = Cont | {2'b0, v[17:12]};
          conv_o.bytes[2] = Cont | {2'b0, v[11:6]};
          conv_o.bytes[3] = Cont | {2'b0, v[5:0]};
          state_o.pend_valid = 1'b0;
          state_o.pend_bits  = '0;
          state_o.count      = cnt_next;
        end
      end else if ((w & AsciiMask) == 16'h0000) begin
        conv_o.nres     = CntBits'(1);
        conv_o.bytes[0] = w[7:0];
        state_o.count   = cnt_next;
      end else if ((w & TwoByteMask) == 16'h0000) begin
        conv_o.nres     = CntBits'(2);
        conv_o.bytes[0] = Lead2 | {3'b0, w[10:6]};
        conv_o.bytes[1] = Cont | {2'b0, w[5:0]};
        state_o.count   = cnt_next;
      end else if ((w & TwoByteMask) != SurrHiBase) begin
        conv_o.nres     = CntBits'(3);
        conv_o.bytes[0] = Lead3 | {4'b0, w[15:12]};
        conv_o.bytes[1] = Cont | {2'b0, w[11:6]};
        conv_o.bytes[2] = Cont | {2'b0, w[5:0]};
        state_o.count   = cnt_next;
      end else if ((hi > SurrSpan) || word_i.final_unit) begin
        // lone low surrogate, or high surrogate closing the stream
        conv_o.nres        = CntBits'(1);
        conv_o.err         = 1'b1;
        conv_o.err_pos     = pos_ext[ErrPosBits-1:0];
        state_o.halted     = 1'b1;
        state_o.pend_valid = 1'b0;
        state_o.pend_bits  = '0;
      end else begin
        // hold the high surrogate
        state_o.pend_bits  = hi[9:0];
        state_o.pend_valid = 1'b1;
        state_o.count      = cnt_next;
      end
    end
  end

endmodule

// File: hw/rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Each input word is one 16-bit code unit (byte-swapped
// first when the byte-swap bit of register 0 is set); each output word is one UTF-8
// byte, with last_of_run on the final byte of a unit. A unit gives 1 to 3 bytes, a high
// surrogate is held and the following low surrogate gives 4 bytes. An invalid surrogate
// gives one error word carrying the unit position, after which all input is consumed
// silently until reset.
// Timing: an input word is registered, converted in one pass and loaded into a 4-byte
// output shift register that drains one byte per cycle while the sink is ready. A unit
// holds the output until all of its bytes (1 to 4) are taken; units that give no byte
// (held high surrogate, halted) are consumed without waiting for the output. The first
// byte appears once the unit has passed the input register and been loaded for output.
`include "utf16_to_utf8_transcoder_assert.svh"

module utf16_to_utf8_transcoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u2u_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u2u_pkg::out_word_t  out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import u2u_pkg::*;

  logic                      swap_q;
  logic                      in_valid_q;
  in_word_t                  in_word_q;
  state_t                    state_q;
  state_t                    state_d;
  conv_t                     conv;
  logic [CntBits-1:0]        cnt_q;
  logic [MaxBytes-1:0][7:0]  bytes_q;
  logic                      err_q;
  logic [ErrPosBits-1:0]     err_pos_q;
  logic                      take;
  logic                      buf_free;
  logic                      advance;
  logic                      load;
  logic                      cfg_wr;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegSwapBytes) ? {31'b0, swap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == RegSwapBytes)) begin
      swap_q <= pwdata[0];
    end
  end

  // Conversion of the registered unit
  u2u_conv u_conv (
    .word_i  (in_word_q),
    .swap_i  (swap_q),
    .state_i (state_q),
    .state_o (state_d),
    .conv_o  (conv)
  );

  // Handshake
  assign take      = out_valid_o && out_ready_i;
  assign buf_free  = (cnt_q == '0) || ((cnt_q == CntBits'(1)) && out_ready_i);
  assign advance   = in_valid_q && (buf_free || (conv.nres == '0));
  assign load      = advance && (conv.nres != '0);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
  end

  // Stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= conv.nres;
    end else if (take) begin
      cnt_q <= cnt_q - CntBits'(1);
    end
  end

  // Output shift register
  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q   <= conv.bytes;
      err_q     <= conv.err;
      err_pos_q <= conv.err_pos;
    end else if (take) begin
      bytes_q <= {8'h00, bytes_q[MaxBytes-1:1]};
    end
  end

  assign out_valid_o               = (cnt_q != '0);
  assign out_word_o.out_byte       = bytes_q[0];
  assign out_word_o.last_of_run    = (cnt_q == CntBits'(1));
  assign out_word_o.error          = err_q;
  assign out_word_o.error_position = err_pos_q;

  // Checks
  `U2U_ASSERT_IMP(a_halt_no_load, state_q.halted, !load, "bytes loaded while halted")
  `U2U_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntBits'(MaxBytes), "byte count overflow")
  `U2U_ASSERT_IMP(a_halt_no_pend, state_q.halted, !state_q.pend_valid, "surrogate held after halt")
  `U2U_ASSERT_NXT(a_err_halts, load && conv.err, state_q.halted, "error did not halt")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import u2u_pkg::*;

  localparam int unsigned IdlePct     = 13;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseChars  = 62;
  localparam int unsigned FinalPct    = 8;
  localparam logic [2:0]  SwapAddr    = {RegSwapBytes, 2'b00};

  // How the stream is broken at the end of the run
  typedef enum logic [1:0] {
    ErrBadPair,
    ErrLoneLow,
    ErrFinalHigh
  } surr_err_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_word_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the transcoder state
  logic [9:0]  held_hi;
  logic        held_valid;
  logic        stream_halted;
  logic [31:0] unit_pos;
  logic        swap_cfg;

  out_word_t   utf8_bytes_q [$];
  out_word_t   want;
  int          error_count;
  bit          steady;
  int unsigned quiet_cycles;

  utf16_to_utf8_transcoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink backpressure
  always @(posedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= IdlePct);
  end

  // Error word: stream stops here until reset
  task automatic push_surr_error(input logic [31:0] pos);
    out_word_t o;
    o = '0;
    o.last_of_run    = 1'b1;
    o.error          = 1'b1;
    o.error_position = pos;
    utf8_bytes_q.push_back(o);
    stream_halted = 1'b1;
    held_valid    = 1'b0;
    held_hi       = '0;
  endtask

  // Expected UTF-8 words for one accepted code unit
  task automatic predict_utf8(input in_word_t w);
    logic [15:0] u;
    logic [15:0] off;
    logic [20:0] cp;
    logic [7:0]  b [4];
    int          n;
    out_word_t   o;
    n = 0;
    if (stream_halted) return;
    u = swap_cfg ? {w.code_unit[7:0], w.code_unit[15:8]} : w.code_unit;
    if (held_valid) begin
      off = u - SurrLoBase;
      if (off > SurrSpan) begin
        // error points back at the held high surrogate
        push_surr_error(unit_pos - 32'd1);
        return;
      end
      cp = 21'({held_hi, 10'b0}) + 21'(off[9:0]) + SuppBase;
      b[0] = Lead4 | 8'(cp[20:18]);
      b[1] = Cont | 8'(cp[17:12]);
      b[2] = Cont | 8'(cp[11:6]);
      b[3] = Cont | 8'(cp[5:0]);
      n = 4;
      held_valid = 1'b0;
      held_hi    = '0;
    end else if ((u & AsciiMask) == '0) begin
      b[0] = u[7:0];
      n = 1;
    end else if ((u & TwoByteMask) == '0) begin
      b[0] = Lead2 | 8'(u[10:6]);
      b[1] = Cont | 8'(u[5:0]);
      n = 2;
    end else if ((u & TwoByteMask) != SurrHiBase) begin
      b[0] = Lead3 | 8'(u[15:12]);
      b[1] = Cont | 8'(u[11:6]);
      b[2] = Cont | 8'(u[5:0]);
      n = 3;
    end else begin
      off = u - SurrHiBase;
      // lone low surrogate, or high surrogate that ends the stream
      if (off > SurrSpan || w.final_unit) begin
        push_surr_error(unit_pos);
        return;
      end
      held_hi    = off[9:0];
      held_valid = 1'b1;
    end
    unit_pos = w.final_unit ? '0 : unit_pos + 32'd1;
    for (int k = 0; k < n; k++) begin
      o = '0;
      o.out_byte    = b[k];
      o.last_of_run = (k == n - 1);
      utf8_bytes_q.push_back(o);
    end
  endtask

  // Send one code unit, given in logical byte order
  task automatic send_unit(input logic [15:0] unit, input logic fin);
    in_word_t w;
    w.code_unit  = swap_cfg ? {unit[7:0], unit[15:8]} : unit;
    w.final_unit = fin;
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_utf8(in_word_i);
  endtask

  // One well-formed character: 1 to 3 byte unit or a surrogate pair
  task automatic send_random_char(input logic fin);
    int unsigned pick;
    logic [15:0] u;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_unit(16'($urandom_range(16'h007F)), fin);
    end else if (pick < 30) begin
      send_unit(16'($urandom_range(16'h07FF, 16'h0080)), fin);
    end else if (pick < 65) begin
      u = 16'($urandom_range(16'hFFFF, 16'h0800));
      // move surrogates up into the F800-FFFF range
      if (u[15:11] == 5'b11011) u = u ^ 16'h2000;
      send_unit(u, fin);
    end else begin
      send_unit(SurrHiBase | 16'($urandom_range(16'h03FF)), 1'b0);
      send_unit(SurrLoBase | 16'($urandom_range(16'h03FF)), fin);
    end
  endtask

  // Wait until every predicted word has been delivered
  task automatic drain();
    in_valid_i <= 1'b0;
    while (utf8_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the byte-swap bit with junk in the upper bits, then read it back
  task automatic write_swap(input logic val);
    logic [31:0] data;
    data    = $urandom();
    data[0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SwapAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    swap_cfg = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, val}) begin
      $error("prdata: expected %h, got %h", {31'b0, val}, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Boundaries of every length class and of the supplementary range
  task automatic test_bmp_extremes();
    write_swap(1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b1);
    send_unit(16'h0041, 1'b1);
    drain();
  endtask

  // Byte-swapped input
  task automatic test_swapped_units();
    write_swap(1'b1);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h00E9, 1'b0);
    send_unit(16'h20AC, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC37, 1'b1);
    send_unit(16'hFFFD, 1'b0);
    drain();
  endtask

  task automatic test_random_stream(input logic swap, input bit no_gaps);
    write_swap(swap);
    steady = no_gaps;
    repeat (PhaseChars) send_random_char($urandom_range(99) < FinalPct);
    drain();
    steady = 1'b0;
  endtask

  // Break the stream once, then check that everything after is swallowed
  task automatic test_surrogate_error();
    surr_err_e   err_kind;
    logic [15:0] u;
    err_kind = surr_err_e'($urandom_range(2));
    write_swap(1'($urandom_range(1)));
    repeat ($urandom_range(6, 1)) send_random_char(1'b0);
    // position count restarts after a final unit
    send_random_char(1'b1);
    repeat ($urandom_range(5)) send_random_char(1'b0);
    case (err_kind)
      ErrBadPair: begin
        send_unit(SurrHiBase | 16'($urandom_range(16'h03FF)), 1'b0);
        u = 16'($urandom());
        if (u[15:10] == 6'b110111) u[15:10] = 6'b110110;
        send_unit(u, 1'($urandom_range(1)));
      end
      ErrLoneLow: begin
        send_unit(SurrLoBase | 16'($urandom_range(16'h03FF)), 1'($urandom_range(1)));
      end
      default: begin
        send_unit(SurrHiBase | 16'($urandom_range(16'h03FF)), 1'b1);
      end
    endcase
    repeat (12) send_unit(16'($urandom()), 1'($urandom_range(1)));
    drain();
  endtask

  // Compare each delivered word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (utf8_bytes_q.size() == 0) begin
        $error("unexpected word: out_byte %h error %b position %h",
               out_word_o.out_byte, out_word_o.error, out_word_o.error_position);
        error_count++;
      end else begin
        want = utf8_bytes_q.pop_front();
        if (out_word_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_word_o.out_byte);
          error_count++;
        end
        if (out_word_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run,
                 out_word_o.last_of_run);
          error_count++;
        end
        if (out_word_o.error !== want.error) begin
          $error("error: expected %b, got %b", want.error, out_word_o.error);
          error_count++;
        end
        if (out_word_o.error_position !== want.error_position) begin
          $error("error_position: expected %h, got %h", want.error_position,
                 out_word_o.error_position);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    held_hi       = '0;
    held_valid    = 1'b0;
    stream_halted = 1'b0;
    unit_pos      = '0;
    swap_cfg      = 1'b0;
    error_count   = 0;
    steady        = 1'b0;
    quiet_cycles  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bmp_extremes();
    test_swapped_units();
    test_random_stream(1'b0, 1'b0);
    test_random_stream(1'b1, 1'b0);
    test_random_stream(1'b1, 1'b1);
    test_random_stream(1'b0, 1'b0);
    test_surrogate_error();

    if (utf8_bytes_q.size() != 0) begin
      $error("%0d expected words never arrived", utf8_bytes_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/u2u_pkg.sv
hw/rtl/u2u_conv.sv
hw/rtl/utf16_to_utf8_transcoder.sv
verif/tb_top.sv
